// ===== hw/rtl/igog_pkg.sv =====
// shared types, constants and helpers for the im2col gather offset generator
package igog_pkg;

	localparam int MAX_DIM      = 64;
	localparam int MAX_CHANNELS = 256;
	localparam int MAX_KERNEL   = 3;
	localparam int MAX_STEP     = 4;

	localparam int OFS_W   = 22;
	localparam int HALF_W  = 21;
	localparam int DIM_W   = 7;
	localparam int CHAN_W  = 9;
	localparam int KDIM_W  = 2;
	localparam int STEP_W  = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam int POS_XY_W = 6;
	localparam int POS_C_W  = 8;
	localparam int POS_K_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INPUT_WIDTH   = 3'd0,
		CFG_INPUT_HEIGHT  = 3'd1,
		CFG_CHANNEL_COUNT = 3'd2,
		CFG_KERNEL_DIM    = 3'd3,
		CFG_STEP_SIZE     = 3'd4,
		CFG_OUTPUT_WIDTH  = 3'd5,
		CFG_OUTPUT_HEIGHT = 3'd6
	} cfg_idx_t;

	// zero acts as one, values above the limit saturate
	function automatic logic [CFG_DATA_W-1:0] clamp_cfg(input logic [CFG_DATA_W-1:0] v,
			input logic [CFG_DATA_W-1:0] hi);
		logic [CFG_DATA_W-1:0] r;
		if (v == '0)
			r = CFG_DATA_W'(1);
		else if (v > hi)
			r = hi;
		else
			r = v;
		return r;
	endfunction

endpackage

// ===== hw/rtl/im2col_gather_offset_generator_unit.sv =====
// top level of the im2col gather offset generator
//
//  channel | signals                              | handshake
//  --------+--------------------------------------+-------------------------
//  in      | restart                              | in_valid / in_stall
//  out     | wide_offset, half_offset, last       | out_valid / out_stall
//  cfg     | cfg_index, cfg_data                  | cfg_valid / cfg_ready
//
// one offset per cycle while in_stall is low: each accepted request is computed
// from the position counters in the same cycle and is held in the output register
// in_stall rises only while the output register is full and out_stall is high
// cfg_ready is always high; a write to a defined index clears position and running bases
// arst_n sets the reset configuration, position zero and an empty output register
module im2col_gather_offset_generator_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               restart,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [igog_pkg::OFS_W-1:0]         wide_offset,
	output logic [igog_pkg::HALF_W-1:0]        half_offset,
	output logic                               last,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [igog_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [igog_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import igog_pkg::*;

	logic [DIM_W-1:0]  iw_q, ih_q, ow_q, oh_q;
	logic [CHAN_W-1:0] ch_q;
	logic [KDIM_W-1:0] k_q;
	logic [STEP_W-1:0] s_q;

	logic [DIM_W-1:0]  iw_e, ih_e, ow_e, oh_e;
	logic [CHAN_W-1:0] ch_e;
	logic [KDIM_W-1:0] k_e;
	logic [STEP_W-1:0] s_e;

	logic [POS_XY_W-1:0] col_q, row_q, col_c, row_c, col_n, row_n;
	logic [POS_C_W-1:0]  chan_q, chan_c, chan_n;
	logic [POS_K_W-1:0]  krow_q, kcol_q, krow_c, kcol_c, krow_n, kcol_n;
	logic [OFS_W-1:0]    pb_q, cb_q, pb_c, cb_c, pb_n, cb_n;

	logic [OFS_W-1:0]  wide_c, wide_q;
	logic              last_c, last_q, out_valid_q;
	logic [10:0]       kterm;
	logic [OFS_W-1:0]  plane_step, col_step, row_back, row_fwd;
	logic              kc_end, kr_end, c_end, x_end, y_end;
	logic              in_xfer, cfg_xfer, cfg_hit;

	assign iw_e = DIM_W'(clamp_cfg(CFG_DATA_W'(iw_q), CFG_DATA_W'(MAX_DIM)));
	assign ih_e = DIM_W'(clamp_cfg(CFG_DATA_W'(ih_q), CFG_DATA_W'(MAX_DIM)));
	assign ow_e = DIM_W'(clamp_cfg(CFG_DATA_W'(ow_q), CFG_DATA_W'(MAX_DIM)));
	assign oh_e = DIM_W'(clamp_cfg(CFG_DATA_W'(oh_q), CFG_DATA_W'(MAX_DIM)));
	assign ch_e = clamp_cfg(ch_q, CFG_DATA_W'(MAX_CHANNELS));
	assign k_e  = KDIM_W'(clamp_cfg(CFG_DATA_W'(k_q), CFG_DATA_W'(MAX_KERNEL)));
	assign s_e  = STEP_W'(clamp_cfg(CFG_DATA_W'(s_q), CFG_DATA_W'(MAX_STEP)));

	assign in_stall  = out_valid_q & out_stall;
	assign in_xfer   = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid & cfg_ready;

	always_comb begin
		case (cfg_idx_t'(cfg_index))
			CFG_INPUT_WIDTH, CFG_INPUT_HEIGHT, CFG_CHANNEL_COUNT, CFG_KERNEL_DIM,
			CFG_STEP_SIZE, CFG_OUTPUT_WIDTH, CFG_OUTPUT_HEIGHT: cfg_hit = 1'b1;
			default: cfg_hit = 1'b0;
		endcase
	end

	// step constants in bytes
	always_comb begin
		plane_step = OFS_W'({14'(iw_e) * 14'(ih_e), 2'b00});
		col_step   = OFS_W'({s_e, 2'b00});
		row_back   = OFS_W'({10'(ow_e - DIM_W'(1)) * 10'(s_e), 2'b00});
		row_fwd    = OFS_W'({10'(s_e) * 10'(iw_e), 2'b00});
	end

	always_comb begin
		col_c  = restart ? '0 : col_q;
		row_c  = restart ? '0 : row_q;
		chan_c = restart ? '0 : chan_q;
		krow_c = restart ? '0 : krow_q;
		kcol_c = restart ? '0 : kcol_q;
		pb_c   = restart ? '0 : pb_q;
		cb_c   = restart ? '0 : cb_q;

		kterm  = {9'(krow_c) * 9'(iw_e) + 9'(kcol_c), 2'b00};
		wide_c = pb_c + cb_c + OFS_W'(kterm);

		kc_end = (3'(kcol_c) + 3'd1) >= 3'(k_e);
		kr_end = (3'(krow_c) + 3'd1) >= 3'(k_e);
		c_end  = (9'(chan_c) + 9'd1) >= ch_e;
		x_end  = (7'(col_c) + 7'd1) >= ow_e;
		y_end  = (7'(row_c) + 7'd1) >= oh_e;
		last_c = kc_end & kr_end & c_end & x_end & y_end;

		col_n  = col_c;
		row_n  = row_c;
		chan_n = chan_c;
		krow_n = krow_c;
		kcol_n = kcol_c;
		pb_n   = pb_c;
		cb_n   = cb_c;
		if (!kc_end) begin
			kcol_n = kcol_c + POS_K_W'(1);
		end else begin
			kcol_n = '0;
			if (!kr_end) begin
				krow_n = krow_c + POS_K_W'(1);
			end else begin
				krow_n = '0;
				if (!c_end) begin
					chan_n = chan_c + POS_C_W'(1);
					cb_n   = cb_c + plane_step;
				end else begin
					chan_n = '0;
					cb_n   = '0;
					if (!x_end) begin
						col_n = col_c + POS_XY_W'(1);
						pb_n  = pb_c + col_step;
					end else begin
						col_n = '0;
						if (!y_end) begin
							row_n = row_c + POS_XY_W'(1);
							pb_n  = pb_c - row_back + row_fwd;
						end else begin
							row_n = '0;
							pb_n  = '0;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q <= DIM_W'(3);
			ih_q <= DIM_W'(3);
			ch_q <= CHAN_W'(1);
			k_q  <= KDIM_W'(3);
			s_q  <= STEP_W'(1);
			ow_q <= DIM_W'(1);
			oh_q <= DIM_W'(1);
		end else if (cfg_xfer) begin
			case (cfg_idx_t'(cfg_index))
				CFG_INPUT_WIDTH:   iw_q <= cfg_data[DIM_W-1:0];
				CFG_INPUT_HEIGHT:  ih_q <= cfg_data[DIM_W-1:0];
				CFG_CHANNEL_COUNT: ch_q <= cfg_data;
				CFG_KERNEL_DIM:    k_q  <= cfg_data[KDIM_W-1:0];
				CFG_STEP_SIZE:     s_q  <= cfg_data[STEP_W-1:0];
				CFG_OUTPUT_WIDTH:  ow_q <= cfg_data[DIM_W-1:0];
				CFG_OUTPUT_HEIGHT: oh_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// position and running bases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			chan_q <= '0;
			krow_q <= '0;
			kcol_q <= '0;
			pb_q   <= '0;
			cb_q   <= '0;
		end else if (cfg_xfer && cfg_hit) begin
			col_q  <= '0;
			row_q  <= '0;
			chan_q <= '0;
			krow_q <= '0;
			kcol_q <= '0;
			pb_q   <= '0;
			cb_q   <= '0;
		end else if (in_xfer) begin
			col_q  <= col_n;
			row_q  <= row_n;
			chan_q <= chan_n;
			krow_q <= krow_n;
			kcol_q <= kcol_n;
			pb_q   <= pb_n;
			cb_q   <= cb_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			wide_q <= wide_c;
			last_q <= last_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign wide_offset = wide_q;
	assign half_offset = wide_q[OFS_W-1:1];
	assign last        = last_q;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output register");

	a_xfer_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> out_valid)
		else $error("accepted transfer produced no result");

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && last_c) |=> (col_q == '0 && row_q == '0 && chan_q == '0 &&
			krow_q == '0 && kcol_q == '0 && pb_q == '0 && cb_q == '0))
		else $error("position not wrapped after last offset");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_xfer && cfg_hit) |=> (kcol_q == '0 && chan_q == '0 && pb_q == '0 &&
			cb_q == '0))
		else $error("register write did not clear position");

	a_kcol_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(kcol_q < k_e) && (krow_q < k_e))
		else $error("kernel position out of range");
`endif

endmodule
